// ===== rtl/tmcm_pkg.sv =====
`default_nettype none
package tmcm_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned PageBytesDefault  = 4096;

  localparam int unsigned CapW  = 43;
  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 42;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CapW-1:0]  CapMax       = {CapW{1'b1}};
  localparam logic [CapW-1:0]  FastCapRst   = 43'd17179869184;
  localparam logic [CapW-1:0]  SharedCapRst = 43'd4294967296;
  localparam logic [CapW-1:0]  SystemCapRst = 43'd137438953472;
  localparam logic [CapW-1:0]  StorageCapRst = 43'd2199023255552;
  localparam logic [AddrW-1:0] AddrBaseRst  = 48'd4294967296;

  localparam logic [CfgIdxW-1:0] RegFast    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShared  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSystem  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStorage = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBase    = 3'd4;

  localparam logic [2:0] KindAlloc   = 3'd0;
  localparam logic [2:0] KindFree    = 3'd1;
  localparam logic [2:0] KindMigrate = 3'd2;
  localparam logic [2:0] KindPromote = 3'd3;
  localparam logic [2:0] KindDemote  = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSpace  = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  function automatic logic [7:0] dev_of(input logic [1:0] t);
    case (t)
      2'd0:    dev_of = 8'd0;
      2'd1:    dev_of = 8'd1;
      default: dev_of = 8'hFF;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tmcm_ctrl.sv =====
`default_nettype none
module tmcm_ctrl
  import tmcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid) state_d = S_SCAN;
      S_SCAN: if (sts_i.scan_done) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (out_ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_q == S_IDLE);
    out_valid  = (state_q == S_OUT);
    cmd_o.start = (state_q == S_IDLE) && in_valid;
    cmd_o.scan  = (state_q == S_SCAN);
    cmd_o.exec  = (state_q == S_EXEC);
  end

endmodule
`default_nettype wire

// ===== rtl/tmcm_dp.sv =====
`default_nettype none
module tmcm_dp
  import tmcm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned PAGE_BYTES  = PageBytesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [AddrW-1:0]  cfg_wdata,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic [SizeW-1:0]  size_i,
  input  wire logic [1:0]        tier_i,
  input  wire logic [3:0]        access_pattern_i,
  input  wire logic [AddrW-1:0]  address_i,
  output logic [1:0]             status_o,
  output logic [AddrW-1:0]       block_address_o,
  output logic [1:0]             result_tier_o,
  output logic [7:0]             device_id_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned PageW = $clog2(PAGE_BYTES);

  logic [CapW-1:0]  free_q [4];
  logic [AddrW-1:0] next_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [AddrW-1:0] ent_addr [TABLE_DEPTH];
  logic [SizeW-1:0] ent_size [TABLE_DEPTH];
  logic [1:0]       ent_tier [TABLE_DEPTH];

  logic [2:0]       kind_q;
  logic [SizeW-1:0] size_q;
  logic [1:0]       tier_q;
  logic [3:0]       pat_q;
  logic [AddrW-1:0] addr_q;

  logic [CntW-1:0]  cnt_q;
  logic             empty_found_q, hit_found_q;
  logic [IdxW-1:0]  empty_idx_q, hit_idx_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [SizeW-1:0] rd_size_q;
  logic [1:0]       rd_tier_q;
  logic             rd_valid_q, rd_pend_q;
  logic [IdxW-1:0]  rd_idx_q;

  logic [1:0]       st_q, rt_q;
  logic [AddrW-1:0] ba_q;
  logic             tok_q;

  logic [IdxW-1:0] idx;
  assign idx = cnt_q[IdxW-1:0];
  assign sts_o.scan_done = (cnt_q == CntW'(TABLE_DEPTH)) && !rd_pend_q;

  // table read, registered
  always_ff @(posedge clk_i) begin
    rd_addr_q <= ent_addr[idx];
    rd_size_q <= ent_size[idx];
    rd_tier_q <= ent_tier[idx];
    rd_idx_q  <= idx;
  end

  // hit entry fields captured at scan
  logic [SizeW-1:0] hit_size_q;
  logic [1:0]       hit_tier_q;

  // allocation decision
  logic [1:0] at;
  logic       aok;
  logic [CapW-1:0] sz43;
  assign sz43 = CapW'(size_q);
  always_comb begin
    at  = tier_q;
    aok = 1'b1;
    if (free_q[tier_q] < sz43) begin
      if (!pat_q[3] && free_q[0] >= sz43) at = 2'd0;
      else if ((pat_q[1] || pat_q[3]) && free_q[1] >= sz43) at = 2'd1;
      else if (free_q[2] >= sz43) at = 2'd2;
      else at = 2'd3;
      aok = free_q[at] >= sz43;
    end
  end

  logic [SizeW:0]   rnd;
  logic [AddrW-1:0] inc;
  assign rnd = {1'b0, size_q} + (SizeW+1)'(PAGE_BYTES - 1);
  assign inc = AddrW'({rnd[SizeW:PageW], {PageW{1'b0}}});

  logic [1:0] mtgt;
  always_comb begin
    case (kind_q)
      KindMigrate: mtgt = tier_q;
      KindPromote: mtgt = (hit_tier_q == 2'd0) ? 2'd0 : hit_tier_q - 2'd1;
      default:     mtgt = (hit_tier_q == 2'd3) ? 2'd3 : hit_tier_q + 2'd1;
    endcase
  end

  logic [CapW:0] gb_sum;
  logic [1:0]    gb_t;
  logic [CapW-1:0] gb_sat;
  assign gb_t   = hit_tier_q;
  assign gb_sum = {1'b0, free_q[gb_t]} + (CapW+1)'(hit_size_q);
  assign gb_sat = gb_sum[CapW] ? CapMax : gb_sum[CapW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q <= kind_i; size_q <= size_i; tier_q <= tier_i;
      pat_q <= access_pattern_i; addr_q <= address_i;
    end
    if (cmd_i.scan && rd_valid_q && hit_found_q == 1'b0
        && valid_q[rd_idx_q] && rd_addr_q == addr_q) begin
      hit_size_q <= rd_size_q;
      hit_tier_q <= rd_tier_q;
    end
    if (cmd_i.exec) begin
      st_q <= StOk; ba_q <= '0; rt_q <= 2'd0; tok_q <= 1'b0;
      if (kind_q == KindAlloc) begin
        if (!empty_found_q) st_q <= StFull;
        else if (!aok) st_q <= StNoSpace;
        else begin
          ba_q <= next_q; rt_q <= at; tok_q <= 1'b1;
          ent_addr[empty_idx_q] <= next_q;
          ent_size[empty_idx_q] <= size_q;
          ent_tier[empty_idx_q] <= at;
        end
      end else if (kind_q > KindDemote || !hit_found_q) begin
        st_q <= StNotFound;
      end else if (kind_q == KindFree) begin
        ba_q <= addr_q; rt_q <= hit_tier_q; tok_q <= 1'b1;
      end else begin
        tok_q <= 1'b1;
        if (mtgt == hit_tier_q) begin
          ba_q <= addr_q; rt_q <= hit_tier_q;
        end else if (free_q[mtgt] < CapW'(hit_size_q)) begin
          st_q <= StNoSpace; rt_q <= hit_tier_q;
        end else begin
          ba_q <= addr_q; rt_q <= mtgt;
          ent_tier[hit_idx_q] <= mtgt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q[0] <= FastCapRst; free_q[1] <= SharedCapRst;
      free_q[2] <= SystemCapRst; free_q[3] <= StorageCapRst;
      next_q <= AddrBaseRst;
      valid_q <= '0;
      cnt_q <= '0; rd_valid_q <= 1'b0; rd_pend_q <= 1'b0;
      empty_found_q <= 1'b0; hit_found_q <= 1'b0;
      empty_idx_q <= '0; hit_idx_q <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegFast, RegShared, RegSystem, RegStorage:
            free_q[cfg_index[1:0]] <= cfg_wdata[CapW-1:0];
          RegBase: next_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        cnt_q <= '0; rd_valid_q <= 1'b0; rd_pend_q <= 1'b0;
        empty_found_q <= 1'b0; hit_found_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (cnt_q != CntW'(TABLE_DEPTH)) begin
          cnt_q <= cnt_q + CntW'(1);
          rd_valid_q <= 1'b1;
          rd_pend_q <= 1'b1;
          if (!empty_found_q && !valid_q[idx]) begin
            empty_found_q <= 1'b1; empty_idx_q <= idx;
          end
        end else begin
          rd_valid_q <= 1'b0; rd_pend_q <= 1'b0;
        end
        if (rd_valid_q && !hit_found_q && valid_q[rd_idx_q] && rd_addr_q == addr_q) begin
          hit_found_q <= 1'b1; hit_idx_q <= rd_idx_q;
        end
      end
      if (cmd_i.exec) begin
        if (kind_q == KindAlloc) begin
          if (empty_found_q && aok) begin
            valid_q[empty_idx_q] <= 1'b1;
            free_q[at] <= free_q[at] - sz43;
            next_q <= next_q + inc;
          end
        end else if (kind_q <= KindDemote && hit_found_q) begin
          if (kind_q == KindFree) begin
            valid_q[hit_idx_q] <= 1'b0;
            free_q[gb_t] <= gb_sat;
          end else if (mtgt != hit_tier_q && free_q[mtgt] >= CapW'(hit_size_q)) begin
            free_q[gb_t] <= gb_sat;
            free_q[mtgt] <= free_q[mtgt] - CapW'(hit_size_q);
          end
        end
      end
    end
  end

  assign status_o        = st_q;
  assign block_address_o = ba_q;
  assign result_tier_o   = tok_q ? rt_q : 2'd0;
  assign device_id_o     = tok_q ? dev_of(rt_q) : 8'd0;

endmodule
`default_nettype wire

// ===== rtl/tiered_memory_capacity_manager_core.sv =====
// channel | handshake                 | payload
// request | in_valid / in_ready       | kind_i size_i tier_i access_pattern_i address_i
// result  | out_valid / out_ready     | status_o block_address_o result_tier_o device_id_o
// config  | cfg_we                    | cfg_index cfg_wdata
// A request accepted in idle scans the table through a registered read port, then
// passes through one update state; the result is offered in the cycle after the update.
// The result is held until taken; the next request is accepted only once the controller
// is back in idle, so a new request is not taken before the last result is handed over.
// Reset restores capacities, the address base and clears all entry valid bits.
`default_nettype none
module tiered_memory_capacity_manager_core
  import tmcm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned PAGE_BYTES  = PageBytesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [AddrW-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         kind_i,
  input  wire logic [SizeW-1:0]   size_i,
  input  wire logic [1:0]         tier_i,
  input  wire logic [3:0]         access_pattern_i,
  input  wire logic [AddrW-1:0]   address_i,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status_o,
  output logic [AddrW-1:0]        block_address_o,
  output logic [1:0]              result_tier_o,
  output logic [7:0]              device_id_o
);

  cmd_t cmd;
  sts_t sts;

  tmcm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  tmcm_dp #(.TABLE_DEPTH(TABLE_DEPTH), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk_i, .rst_ni, .cfg_we, .cfg_index, .cfg_wdata,
    .cmd_i(cmd), .sts_o(sts),
    .kind_i, .size_i, .tier_i, .access_pattern_i, .address_i,
    .status_o, .block_address_o, .result_tier_o, .device_id_o
  );

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != StOk |-> block_address_o == '0)
    else $error("address on failure");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.scan, cmd.exec})) else $error("command overlap");

endmodule
`default_nettype wire

// ===== tb/tiered_memory_capacity_manager_checker.sv =====
`timescale 1ns / 1ps
module tiered_memory_capacity_manager_checker
  import tmcm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         kind_i,
  input  logic [SizeW-1:0]   size_i,
  input  logic [1:0]         tier_i,
  input  logic [3:0]         access_pattern_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status_o,
  input  logic [AddrW-1:0]   block_address_o,
  input  logic [1:0]         result_tier_o,
  input  logic [7:0]         device_id_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Depth = TableDepthDefault;
  localparam logic [63:0] PageB = 64'(PageBytesDefault);

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] addr;
    logic [1:0]       tier;
    logic [7:0]       dev;
  } answer_t;

  answer_t          answer_q[$];
  logic [CapW-1:0]  free_bytes[4];
  logic [AddrW-1:0] next_addr;
  logic             ent_valid[Depth];
  logic [AddrW-1:0] ent_addr[Depth];
  logic [SizeW-1:0] ent_size[Depth];
  logic [1:0]       ent_tier[Depth];
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = answer_q.size();

  function automatic logic [7:0] tier_dev(input logic [1:0] t);
    return (t == 2'd0) ? 8'd0 : ((t == 2'd1) ? 8'd1 : 8'hFF);
  endfunction

  function automatic answer_t make_answer(input logic [1:0] st, input logic [AddrW-1:0] a,
                                          input logic [1:0] t, input logic tier_ok);
    answer_t r;
    r.status = st;
    r.addr   = a;
    r.tier   = tier_ok ? t : 2'd0;
    r.dev    = tier_ok ? tier_dev(t) : 8'd0;
    return r;
  endfunction

  task automatic refund(input logic [1:0] t, input logic [SizeW-1:0] n);
    logic [CapW:0] s;
    s = {1'b0, free_bytes[t]} + n;
    free_bytes[t] = s > {1'b0, CapMax} ? CapMax : s[CapW-1:0];
  endtask

  task automatic predict_request(input logic [2:0] kind, input logic [SizeW-1:0] sz,
                                 input logic [1:0] tr, input logic [3:0] pat,
                                 input logic [AddrW-1:0] a, output answer_t r);
    int e;
    logic [1:0] t;
    logic [1:0] cur;
    logic [1:0] tgt;
    logic [63:0] step;
    e = -1;
    if (kind == KindAlloc) begin
      for (int i = 0; i < Depth; i++)
        if (!ent_valid[i] && e < 0) e = i;
      if (e < 0) begin
        r = make_answer(StFull, '0, 2'd0, 1'b0);
        return;
      end
      if (free_bytes[tr] >= sz) begin
        t = tr;
      end else begin
        if (!pat[3] && free_bytes[0] >= sz) t = 2'd0;
        else if ((pat[1] || pat[3]) && free_bytes[1] >= sz) t = 2'd1;
        else if (free_bytes[2] >= sz) t = 2'd2;
        else t = 2'd3;
        if (free_bytes[t] < sz) begin
          r = make_answer(StNoSpace, '0, 2'd0, 1'b0);
          return;
        end
      end
      r = make_answer(StOk, next_addr, t, 1'b1);
      step = ((64'(sz) + PageB - 1) / PageB) * PageB;
      ent_valid[e] = 1'b1;
      ent_addr[e]  = next_addr;
      ent_size[e]  = sz;
      ent_tier[e]  = t;
      free_bytes[t] = free_bytes[t] - sz;
      next_addr = next_addr + step[AddrW-1:0];
      return;
    end
    if (kind > KindDemote) begin
      r = make_answer(StNotFound, '0, 2'd0, 1'b0);
      return;
    end
    for (int i = 0; i < Depth; i++)
      if (ent_valid[i] && ent_addr[i] == a && e < 0) e = i;
    if (e < 0) begin
      r = make_answer(StNotFound, '0, 2'd0, 1'b0);
      return;
    end
    cur = ent_tier[e];
    if (kind == KindFree) begin
      refund(cur, ent_size[e]);
      ent_valid[e] = 1'b0;
      r = make_answer(StOk, a, cur, 1'b1);
      return;
    end
    if (kind == KindMigrate) tgt = tr;
    else if (kind == KindPromote) tgt = (cur == 2'd0) ? 2'd0 : cur - 2'd1;
    else tgt = (cur == 2'd3) ? 2'd3 : cur + 2'd1;
    if (tgt == cur) begin
      r = make_answer(StOk, a, cur, 1'b1);
    end else if (free_bytes[tgt] < ent_size[e]) begin
      r = make_answer(StNoSpace, '0, cur, 1'b1);
    end else begin
      refund(cur, ent_size[e]);
      free_bytes[tgt] = free_bytes[tgt] - ent_size[e];
      ent_tier[e] = tgt;
      r = make_answer(StOk, a, tgt, 1'b1);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t r;
    if (!rst_ni) begin
      answer_q.delete();
      free_bytes[0] = FastCapRst;
      free_bytes[1] = SharedCapRst;
      free_bytes[2] = SystemCapRst;
      free_bytes[3] = StorageCapRst;
      next_addr = AddrBaseRst;
      for (int i = 0; i < Depth; i++) begin
        ent_valid[i] = 1'b0;
        ent_addr[i]  = '0;
        ent_size[i]  = '0;
        ent_tier[i]  = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report("unexpected result", {62'd0, status_o}, 64'd0);
        end else begin
          r = answer_q.pop_front();
          if (status_o !== r.status) report("status", status_o, r.status);
          if (block_address_o !== r.addr) report("block_address", block_address_o, r.addr);
          if (result_tier_o !== r.tier) report("result_tier", result_tier_o, r.tier);
          if (device_id_o !== r.dev) report("device_id", device_id_o, r.dev);
        end
      end
      if (cfg_we) begin
        if (cfg_index <= RegStorage) free_bytes[cfg_index[1:0]] = cfg_wdata[CapW-1:0];
        else if (cfg_index == RegBase) next_addr = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_request(kind_i, size_i, tier_i, access_pattern_i, address_i, r);
        answer_q.insert(answer_q.size(), r);
      end
    end
  end

endmodule

// ===== tb/tiered_memory_capacity_manager_core_tb.sv =====
`timescale 1ns / 1ps
module tiered_memory_capacity_manager_core_tb;
  import tmcm_pkg::*;

  localparam int CycleLimit = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [AddrW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         kind_i = '0;
  logic [SizeW-1:0]   size_i = '0;
  logic [1:0]         tier_i = '0;
  logic [3:0]         access_pattern_i = '0;
  logic [AddrW-1:0]   address_i = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status_o;
  logic [AddrW-1:0]   block_address_o;
  logic [1:0]         result_tier_o;
  logic [7:0]         device_id_o;
  int                 fail_count;
  int                 pending;
  int                 tx_pct = 17;
  int                 rx_pct = 45;
  int                 cycles = 0;
  logic [AddrW-1:0]   live_addr[$];

  always #2 clk_i = ~clk_i;

  tiered_memory_capacity_manager_core dut (.*);

  tiered_memory_capacity_manager_checker u_checker (
    .clk_i, .rst_ni, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_ready, .kind_i,
    .size_i, .tier_i, .access_pattern_i, .address_i, .out_valid, .out_ready, .status_o,
    .block_address_o, .result_tier_o, .device_id_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rx_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready && status_o == StOk) begin
      live_addr.insert(live_addr.size(), block_address_o);
      if (live_addr.size() > 80) void'(live_addr.pop_front());
    end
  end

  task automatic send(input logic [2:0] k, input logic [SizeW-1:0] sz, input logic [1:0] t,
                      input logic [3:0] pat, input logic [AddrW-1:0] a);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    kind_i <= k;
    size_i <= sz;
    tier_i <= t;
    access_pattern_i <= pat;
    address_i <= a;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_addr();
    if (live_addr.size() != 0 && $urandom_range(99) < 85)
      return live_addr[$urandom_range(live_addr.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_request(input logic big_sizes);
    int sel;
    logic [SizeW-1:0] sz;
    sel = $urandom_range(99);
    sz = $urandom_range(0, 3) == 0 ? SizeW'($urandom_range(0, 300000)) : SizeW'($urandom_range(0, 20000));
    if (big_sizes && $urandom_range(9) == 0) sz = {$urandom, $urandom};
    if (sel < 45) send(KindAlloc, sz, $urandom, $urandom, {$urandom, $urandom});
    else if (sel < 65) send(KindFree, {$urandom, $urandom}, $urandom, $urandom, pick_addr());
    else if (sel < 80) send(KindMigrate, {$urandom, $urandom}, $urandom, $urandom, pick_addr());
    else if (sel < 89) send(KindPromote, {$urandom, $urandom}, $urandom, $urandom, pick_addr());
    else if (sel < 98) send(KindDemote, {$urandom, $urandom}, $urandom, $urandom, pick_addr());
    else send(3'($urandom_range(5, 7)), {$urandom, $urandom}, $urandom, $urandom, pick_addr());
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(KindAlloc, '0, 2'd0, 4'h0, '0);
    send(KindAlloc, {SizeW{1'b1}}, 2'd3, 4'hF, '0);
    send(KindAlloc, 42'd4096, 2'd3, 4'h0, '0);
    send(KindAlloc, 42'd4097, 2'd2, 4'h2, '0);
    send(KindAlloc, 42'd20000000000, 2'd1, 4'h8, '0);
    send(KindAlloc, 42'd20000000000, 2'd1, 4'h2, '0);
    send(KindAlloc, 42'd5000000000, 2'd1, 4'h0, '0);
    send(KindAlloc, 42'd200000000000, 2'd0, 4'hA, '0);
    send(KindFree, '0, 2'd0, 4'h0, AddrBaseRst);
    send(KindFree, '0, 2'd0, 4'h0, {AddrW{1'b1}});
    send(KindMigrate, '0, 2'd3, 4'h0, AddrBaseRst + 48'h1000);
    send(KindMigrate, '0, 2'd3, 4'h0, AddrBaseRst + 48'h1000);
    send(KindPromote, '0, 2'd0, 4'h0, AddrBaseRst + 48'h1000);
    send(KindPromote, '0, 2'd0, 4'h0, AddrBaseRst + 48'h3000);
    send(KindDemote, '0, 2'd0, 4'h0, AddrBaseRst + 48'h3000);
    send(KindDemote, '0, 2'd0, 4'h0, AddrBaseRst + 48'h1000);
    send(3'd5, '0, 2'd0, 4'h0, AddrBaseRst);
    send(3'd6, '0, 2'd0, 4'h0, AddrBaseRst);
    send(3'd7, {SizeW{1'b1}}, 2'd3, 4'hF, {AddrW{1'b1}});
    drain();

    for (int i = 0; i < 150; i++) random_request(1'b0);
    drain();

    write_reg(RegFast, 48'd60000);
    write_reg(RegShared, 48'd100000);
    write_reg(RegSystem, 48'd0);
    write_reg(RegStorage, 48'd4398046511104);
    write_reg(RegBase, 48'hFFFF_FFFF_8000);
    write_reg(3'd5, {AddrW{1'b1}});
    write_reg(3'd7, '0);
    for (int i = 0; i < 150; i++) random_request(1'b1);
    tx_pct = 45;
    rx_pct = 17;
    drain();
    write_reg(RegStorage, {AddrW{1'b1}});
    for (int i = 0; i < 70; i++) send(KindFree, '0, 2'd0, 4'h0, pick_addr());
    drain();

    write_reg(RegFast, 48'd0);
    write_reg(RegShared, 48'd0);
    write_reg(RegSystem, 48'd4398046511104);
    write_reg(RegStorage, 48'd0);
    write_reg(RegBase, '0);
    for (int i = 0; i < 80; i++) send(KindAlloc, SizeW'($urandom_range(0, 9000)), $urandom,
                                      $urandom, '0);
    drain();
    for (int i = 0; i < 120; i++) random_request(1'b0);
    tx_pct = 0;
    rx_pct = 0;
    drain();

    write_reg(RegFast, 48'd17179869184);
    write_reg(RegShared, 48'd4294967296);
    write_reg(RegSystem, 48'd137438953472);
    write_reg(RegStorage, 48'd2199023255552);
    write_reg(RegBase, 48'h1234_5678_9000);
    for (int i = 0; i < 150; i++) random_request(1'b1);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tmcm_pkg.sv
rtl/tmcm_ctrl.sv
rtl/tmcm_dp.sv
rtl/tiered_memory_capacity_manager_core.sv
tb/tiered_memory_capacity_manager_checker.sv
tb/tiered_memory_capacity_manager_core_tb.sv
